// ===== hw/rtl/gsfr_pkg.sv =====
// Shared constants and types for the gas sensor frame receiver.
package gsfr_pkg;

    localparam int FRAME_LEN  = 10;
    localparam int CELL_COUNT = FRAME_LEN - 1;
    localparam int FILL_W     = $clog2(FRAME_LEN + 1);

    // Byte positions inside a frame
    localparam int POS_SIGN  = 3;
    localparam int POS_WHOLE = 4;
    localparam int POS_FRAC  = 6;

    localparam logic [7:0]  START_BYTE    = 8'hAA;
    localparam logic [7:0]  END_BYTE      = 8'hEE;
    localparam int          SIGN_BIT      = 7;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    // Input item kind
    typedef enum logic
    {
        FUNC_BYTE = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef logic [7:0]        byte_t;
    typedef logic [15:0]       ticks_t;
    typedef logic [FILL_W-1:0] fill_t;

endpackage

// ===== hw/rtl/gsfr_if.sv =====
// Valid/ready channel interfaces for input items and frame results.
interface gsfr_in_if;
    logic              valid;
    logic              ready;
    logic              func;
    gsfr_pkg::byte_t   rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface gsfr_out_if;
    logic              valid;
    logic              ready;
    logic              frame_ok;
    logic              negative;
    logic [15:0]       whole_part;
    gsfr_pkg::byte_t   hundredths;

    modport source (output valid, output frame_ok, output negative, output whole_part,
                    output hundredths, input ready);
    modport sink   (input valid, input frame_ok, input negative, input whole_part,
                    input hundredths, output ready);
endinterface

// ===== hw/rtl/gas_sensor_frame_receiver.sv =====
// Gas sensor frame receiver: start-byte sync, byte chain, timeout and result register.
//
// Usage:
//   rx carries one item per transfer: func = 0 with a received serial byte in
//   rx_byte, or func = 1 for a one millisecond tick. A frame opens on start
//   byte 0xAA and closes after ten stored bytes; the closing transfer yields
//   one result on the result channel. frame_ok is 1 when the tenth byte is
//   0xEE; then negative, whole_part and hundredths carry the reading, else 0.
//   A partly filled frame is dropped on a tick that pushes the idle count
//   past the timeout register (cfg_we / cfg_wdata, reset value 100).
// Timing:
//   One item per cycle while rx is ready. The result register is loaded in the
//   cycle after the transfer of the closing byte. Stored bytes advance through a
//   chain of nine byte cells; the tenth byte is taken straight from rx.
// Reset:
//   rst_n clears the fill count, the idle count, the result valid flag and
//   loads the default timeout. Cell contents are not cleared.
// Stall:
//   rx stays ready while the result register is empty or being taken in the
//   same cycle; when a result waits on a stalled receiver, rx is held off.
module gas_sensor_frame_receiver
(
    input  logic              clk,
    input  logic              rst_n,
    gsfr_in_if.sink           rx,
    gsfr_out_if.source        result,
    input  logic              cfg_we,
    input  gsfr_pkg::ticks_t  cfg_wdata
);
    import gsfr_pkg::*;

    ticks_t timeout_reg;
    ticks_t idle_reg;
    ticks_t idle_next;
    fill_t  fill_reg;
    fill_t  fill_next;

    logic   res_valid_reg;
    logic   res_valid_next;
    logic   res_ok_reg;
    logic   res_ok_next;
    logic   res_neg_reg;
    logic   res_neg_next;
    logic [15:0] res_whole_reg;
    logic [15:0] res_whole_next;
    byte_t  res_frac_reg;
    byte_t  res_frac_next;

    logic   accept;
    logic   is_tick;
    logic   store;
    logic   close;
    logic   ok;
    ticks_t idle_inc;
    byte_t  cell_d [CELL_COUNT];
    byte_t  cell_q [CELL_COUNT];

    assign accept  = rx.valid && rx.ready;
    assign is_tick = (rx.func == FUNC_TICK);

    // Store a byte when a frame is open or it is a start byte
    assign store = accept && !is_tick && ((fill_reg != '0) || (rx.rx_byte == START_BYTE));
    assign close = store && (fill_reg == fill_t'(FRAME_LEN - 1));

    // Byte chain: cell 0 takes the new byte, each cell feeds the next
    assign cell_d[0] = rx.rx_byte;
    for (genvar i = 1; i < CELL_COUNT; i++)
    begin : g_link
        assign cell_d[i] = cell_q[i-1];
    end

    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        gsfr_byte_cell u_cell
        (
            .clk   (clk),
            .shift (store),
            .d     (cell_d[i]),
            .q     (cell_q[i])
        );
    end

    // Saturating idle tick count
    assign idle_inc = (idle_reg == TICK_MAX) ? idle_reg : idle_reg + 16'd1;

    // Advance fill and idle counts
    always_comb
    begin
        idle_next = idle_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (is_tick)
            begin
                idle_next = idle_inc;
                if ((fill_reg != '0) && (idle_inc > timeout_reg))
                begin
                    fill_next = '0;
                end
            end
            else
            begin
                idle_next = '0;
                if (close)
                begin
                    fill_next = '0;
                end
                else if (store)
                begin
                    fill_next = fill_reg + fill_t'(1);
                end
            end
        end
    end

    // Build the result from the chain and the closing byte
    assign ok = (rx.rx_byte == END_BYTE);

    always_comb
    begin
        res_valid_next = res_valid_reg && !result.ready;
        res_ok_next    = res_ok_reg;
        res_neg_next   = res_neg_reg;
        res_whole_next = res_whole_reg;
        res_frac_next  = res_frac_reg;
        if (close)
        begin
            res_valid_next = 1'b1;
            res_ok_next    = ok;
            res_neg_next   = ok && cell_q[CELL_COUNT-1-POS_SIGN][SIGN_BIT];
            res_whole_next = ok ? {cell_q[CELL_COUNT-1-POS_WHOLE],
                                   cell_q[CELL_COUNT-2-POS_WHOLE]} : 16'd0;
            res_frac_next  = ok ? cell_q[CELL_COUNT-1-POS_FRAC] : 8'd0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            idle_reg      <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            idle_reg      <= idle_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_ok_reg    <= res_ok_next;
        res_neg_reg   <= res_neg_next;
        res_whole_reg <= res_whole_next;
        res_frac_reg  <= res_frac_next;
    end

    assign rx.ready          = !res_valid_reg || result.ready;
    assign result.valid      = res_valid_reg;
    assign result.frame_ok   = res_ok_reg;
    assign result.negative   = res_neg_reg;
    assign result.whole_part = res_whole_reg;
    assign result.hundredths = res_frac_reg;

endmodule

// ===== hw/rtl/gsfr_byte_cell.sv =====
// One byte cell of the frame shift chain.
module gsfr_byte_cell
(
    input  logic            clk,
    input  logic            shift,
    input  gsfr_pkg::byte_t d,
    output gsfr_pkg::byte_t q
);
    import gsfr_pkg::*;

    byte_t data_reg;
    byte_t data_next;

    // Take the neighbor's byte when the chain advances
    always_comb
    begin
        data_next = shift ? d : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule
